// File: design/ssp_pkg.sv
package ssp_pkg;

    localparam int CNT_W      = 6;
    localparam int POS_W      = 6;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic             is_count;
        logic [CNT_W-1:0] split_count;
        logic [POS_W-1:0] split_position;
        logic             overflow;
        logic             last_result;
    } result_t;

endpackage

// File: design/ssp_front.sv
module ssp_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] in_data,
    input  logic                                   in_last,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output logic [VALUE_WIDTH-1:0]                 push_key,
    output logic                                   push_last
);
    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic                   last_reg;
    logic                   take;

    assign in_ready   = !valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_key   = key_reg;
    assign push_last  = last_reg;

    // sign bit flipped so that unsigned compares order the values as signed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            key_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                key_reg   <= {~in_data[VALUE_WIDTH-1], in_data[VALUE_WIDTH-2:0]};
                last_reg  <= in_last;
            end
            else if (push_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: design/ssp_queue.sv
module ssp_queue #(
    parameter int WIDTH = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             ready,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push;
    logic             do_pop;

    assign ready   = fill_reg != 2'd2;
    assign valid   = fill_reg != 2'd0;
    assign rdata   = slot_reg[rptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= 1'b0;
            rptr_reg    <= 1'b0;
            fill_reg    <= 2'd0;
            slot_reg[0] <= '0;
            slot_reg[1] <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wptr_reg] <= wdata;
                wptr_reg           <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// File: design/ssp_back.sv
module ssp_back #(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [VALUE_WIDTH-1:0] q_key,
    input  logic                   q_last,
    output logic                   q_pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output ssp_pkg::result_t       out_result
);
    import ssp_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SUF_RD,
        S_SUF_WR,
        S_FWD_RD,
        S_FWD_EV,
        S_CNT_OUT
    } state_t;

    logic [VALUE_WIDTH-1:0] elem_mem [MAX_ITEMS];
    logic [VALUE_WIDTH-1:0] suf_mem  [MAX_ITEMS];
    logic [VALUE_WIDTH-1:0] elem_rdata_reg;
    logic [VALUE_WIDTH-1:0] suf_rdata_reg;

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   ovf_reg;
    logic [AW-1:0]          idx_reg;
    logic [VALUE_WIDTH-1:0] sufmin_reg;
    logic [VALUE_WIDTH-1:0] runmax_reg;
    logic [CNT_W-1:0]       splits_reg;
    logic [CNT_W-1:0]       k_reg;
    logic                   emit_reg;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic                   full;
    logic [CW-1:0]          cnt_m1;
    logic [AW-1:0]          last_idx;
    logic                   elem_we;
    logic                   elem_re;
    logic                   suf_we;
    logic                   suf_re;
    logic [AW-1:0]          suf_raddr;
    logic                   suf_first;
    logic [VALUE_WIDTH-1:0] suf_new;
    logic                   fwd_first;
    logic [VALUE_WIDTH-1:0] max_new;
    logic                   is_split;
    logic                   fwd_end;
    logic                   out_free;
    logic                   emit_stall;
    logic                   out_load;

    assign full      = cnt_reg == CW'(MAX_ITEMS);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign last_idx  = cnt_m1[AW-1:0];
    assign q_pop     = (state_reg == S_LOAD) && q_valid;
    assign elem_we   = q_pop && !full;
    assign elem_re   = (state_reg == S_SUF_RD) || (state_reg == S_FWD_RD);
    assign suf_re    = state_reg == S_FWD_RD;
    assign suf_we    = state_reg == S_SUF_WR;
    assign suf_raddr = idx_reg + AW'(1);

    assign suf_first = idx_reg == last_idx;
    assign suf_new   = (suf_first || elem_rdata_reg < sufmin_reg) ? elem_rdata_reg : sufmin_reg;
    assign fwd_first = idx_reg == '0;
    assign max_new   = (fwd_first || elem_rdata_reg > runmax_reg) ? elem_rdata_reg : runmax_reg;
    assign is_split  = max_new <= suf_rdata_reg;
    assign fwd_end   = (CW'(idx_reg) + CW'(2)) == cnt_reg;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit_stall = emit_reg && is_split && !out_free;

    // a new output beat is loaded by the count state or by a split in the emitting pass
    assign out_load = ((state_reg == S_CNT_OUT) && out_free) ||
                      ((state_reg == S_FWD_EV) && emit_reg && is_split && out_free);

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[cnt_reg[AW-1:0]] <= q_key;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (suf_we)
        begin
            suf_mem[idx_reg] <= suf_new;
        end
        if (suf_re)
        begin
            suf_rdata_reg <= suf_mem[suf_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            sufmin_reg    <= '0;
            runmax_reg    <= '0;
            splits_reg    <= '0;
            k_reg         <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                        if (q_last)
                        begin
                            idx_reg   <= full ? AW'(MAX_ITEMS - 1) : cnt_reg[AW-1:0];
                            state_reg <= S_SUF_RD;
                        end
                    end
                end

                S_SUF_RD:
                begin
                    state_reg <= S_SUF_WR;
                end

                // walk down from the tail, keeping the running minimum
                S_SUF_WR:
                begin
                    sufmin_reg <= suf_new;
                    splits_reg <= '0;
                    emit_reg   <= 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_reg <= (cnt_reg == CW'(1)) ? S_CNT_OUT : S_FWD_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_SUF_RD;
                    end
                end

                S_FWD_RD:
                begin
                    state_reg <= S_FWD_EV;
                end

                // same walk twice: first counts splits, then emits positions
                S_FWD_EV:
                begin
                    if (!emit_stall)
                    begin
                        runmax_reg <= max_new;
                        if (is_split)
                        begin
                            if (emit_reg)
                            begin
                                out_reg.is_count           <= 1'b0;
                                out_reg.split_count        <= '0;
                                out_reg.split_position     <= POS_W'(idx_reg) + POS_W'(1);
                                out_reg.overflow           <= ovf_reg;
                                out_reg.last_result        <= (k_reg + CNT_W'(1)) == splits_reg;
                                k_reg                      <= k_reg + CNT_W'(1);
                            end
                            else
                            begin
                                splits_reg <= splits_reg + CNT_W'(1);
                            end
                        end
                        if (fwd_end)
                        begin
                            if (emit_reg)
                            begin
                                cnt_reg   <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                state_reg <= S_CNT_OUT;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_FWD_RD;
                        end
                    end
                end

                S_CNT_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg.is_count       <= 1'b1;
                        out_reg.split_count    <= splits_reg;
                        out_reg.split_position <= '0;
                        out_reg.overflow       <= ovf_reg;
                        out_reg.last_result    <= splits_reg == '0;
                        if (splits_reg == '0)
                        begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            emit_reg  <= 1'b1;
                            k_reg     <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_FWD_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// File: design/sorted_split_point_finder_top.sv
// Split-point finder.
// Input stream (s_*): one signed value per beat, s_tlast on the final value
// of a sequence. Values past MAX_ITEMS are dropped and flagged as overflow.
// Output stream (m_*): after the closing beat, one count beat (m_tuser = 1)
// and then one beat per split position in ascending order (m_tuser = 0);
// m_tlast marks the final beat of the sequence.
// Loading takes one cycle per value while the back end waits in its load
// state; values reach element memory through the input register and a two-entry queue.
// After the closing beat: a suffix-min pass over the stored values, a
// counting pass, the count beat, then the emitting pass; each memory has
// a single read port.
// Input keeps being taken into the queue during that work until it fills.
// A stalled m_tready holds the output beat and freezes the emitting pass.
// Reset (asynchronous, rst_n low) empties the queue, drops any partial
// sequence and clears the output valid; memories are not cleared.
module sorted_split_point_finder_top #(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // split_count[5:0], split_position[11:6], overflow[12], zero pad
    output logic [ssp_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tuser,  // is_count
    output logic                                   m_tlast
);
    import ssp_pkg::*;

    logic                   f_valid;
    logic                   f_ready;
    logic [VALUE_WIDTH-1:0] f_key;
    logic                   f_last;
    logic [VALUE_WIDTH:0]   q_rdata;
    logic                   q_valid;
    logic                   q_pop;
    result_t                res;

    ssp_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_key   (f_key),
        .push_last  (f_last)
    );

    ssp_queue #(
        .WIDTH(VALUE_WIDTH + 1)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .ready (f_ready),
        .wdata ({f_last, f_key}),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    ssp_back #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_key      (q_rdata[VALUE_WIDTH-1:0]),
        .q_last     (q_rdata[VALUE_WIDTH]),
        .q_pop      (q_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (res)
    );

    assign m_tdata = {{(OUT_DATA_W - CNT_W - POS_W - 1){1'b0}},
                      res.overflow, res.split_position, res.split_count};
    assign m_tuser = res.is_count;
    assign m_tlast = res.last_result;

    // a count beat closes the sequence exactly when there are no splits
    a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tlast == (res.split_count == '0)))
        else $error("count beat last flag disagrees with split count");

    // position beats carry a 1-based position and no count
    a_pos_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (res.split_position != '0) && (res.split_count == '0))
        else $error("malformed position beat");

    // the back end only pops when the queue holds an entry
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// File: tb/split_point_checker.sv
`timescale 1ns / 1ps

module split_point_checker #(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                   s_tlast,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [ssp_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  logic                                   m_tuser,
    input  logic                                   m_tlast,
    output int                                     mismatches,
    output int                                     pending
);

    import ssp_pkg::*;

    logic signed [VALUE_WIDTH-1:0] seq_values[$];
    bit                            seq_overflow = 1'b0;
    result_t                       awaited_results[$];
    result_t                       want;
    int                            error_total = 0;
    int                            awaited_total = 0;

    assign mismatches = error_total;
    assign pending    = awaited_total;

    // Closing beat: evaluate the stored sequence and queue count + position results.
    task automatic predict_splits();
        logic signed [VALUE_WIDTH-1:0] tail_min[MAX_ITEMS];
        logic signed [VALUE_WIDTH-1:0] head_max;
        int                            positions[$];
        result_t                       res;
        int                            n;
        n = seq_values.size();
        tail_min[n-1] = seq_values[n-1];
        for (int i = n - 2; i >= 0; i--)
        begin
            tail_min[i] = (seq_values[i] < tail_min[i+1]) ? seq_values[i] : tail_min[i+1];
        end
        head_max = seq_values[0];
        for (int i = 0; i + 1 < n; i++)
        begin
            if (seq_values[i] > head_max)
            begin
                head_max = seq_values[i];
            end
            if (head_max <= tail_min[i+1])
            begin
                positions.insert(positions.size(), i + 1);
            end
        end
        res             = '0;
        res.is_count    = 1'b1;
        res.split_count = CNT_W'(positions.size());
        res.overflow    = seq_overflow;
        res.last_result = (positions.size() == 0);
        awaited_results.insert(awaited_results.size(), res);
        foreach (positions[k])
        begin
            res                = '0;
            res.split_position = POS_W'(positions[k]);
            res.overflow       = seq_overflow;
            res.last_result    = (k == positions.size() - 1);
            awaited_results.insert(awaited_results.size(), res);
        end
        seq_values.delete();
        seq_overflow = 1'b0;
    endtask

    task automatic check_field(input string field_name, input int expected_val,
                               input int actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s: expected %0d, got %0d", field_name, expected_val, actual_val);
            error_total++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
                           m_tdata, m_tuser, m_tlast);
                    error_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("is_count", int'(want.is_count), int'(m_tuser));
                    check_field("split_count", int'(want.split_count),
                                int'(m_tdata[CNT_W-1:0]));
                    check_field("split_position", int'(want.split_position),
                                int'(m_tdata[CNT_W+POS_W-1:CNT_W]));
                    check_field("overflow", int'(want.overflow), int'(m_tdata[CNT_W+POS_W]));
                    check_field("last_result", int'(want.last_result), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
            begin
                // full store: the value is dropped, the sequence still closes on tlast
                if (seq_values.size() < MAX_ITEMS)
                begin
                    seq_values.insert(seq_values.size(), s_tdata[VALUE_WIDTH-1:0]);
                end
                else
                begin
                    seq_overflow = 1'b1;
                end
                if (s_tlast)
                begin
                    predict_splits();
                end
            end
            awaited_total = awaited_results.size();
        end
    end

endmodule

// File: tb/sorted_split_point_finder_top_tb.sv
`timescale 1ns / 1ps

module sorted_split_point_finder_top_tb;

    import ssp_pkg::*;

    localparam int MAX_ITEMS      = 64;
    localparam int VALUE_WIDTH    = 32;
    localparam int DATA_W         = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASE_ITEMS    = 20;

    typedef enum int {RUN_NOISE, RUN_RISING, RUN_SHUFFLED, RUN_NARROW} run_kind_e;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatches;
    int pending;
    int send_idle_pct = 33;
    int recv_idle_pct = 82;
    int quiet_cycles  = 0;

    logic signed [VALUE_WIDTH-1:0] run_vals[$];

    always #4 clk = ~clk;

    sorted_split_point_finder_top #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    split_point_checker #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // any cycle without a beat on either side counts toward the timeout
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // starts and ends at a falling edge; valid stays high after the beat
    task automatic send_beat(input logic signed [VALUE_WIDTH-1:0] value, input logic closing);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(value);
        s_tlast  <= closing;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_run();
        for (int k = 0; k < run_vals.size(); k++)
        begin
            send_beat(run_vals[k], k == run_vals.size() - 1);
        end
    endtask

    task automatic build_run(input int len, input run_kind_e kind);
        logic signed [VALUE_WIDTH-1:0] v;
        logic signed [VALUE_WIDTH-1:0] tmp;
        int                            j;
        run_vals.delete();
        v = $signed($urandom) >>> 2;
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                RUN_NOISE:  run_vals.insert(run_vals.size(), $urandom);
                RUN_NARROW: run_vals.insert(run_vals.size(),
                                            $signed($urandom_range(0, 6)) - 3);
                default:
                begin
                    v = v + $urandom_range(0, 1000);
                    run_vals.insert(run_vals.size(), v);
                end
            endcase
        end
        // a few local swaps break some of the split points
        if (kind == RUN_SHUFFLED && len > 1)
        begin
            repeat ($urandom_range(1, 3))
            begin
                j = $urandom_range(0, len - 2);
                tmp           = run_vals[j];
                run_vals[j]   = run_vals[j+1];
                run_vals[j+1] = tmp;
            end
        end
    endtask

    function automatic run_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            return RUN_NOISE;
        end
        else if (r <= 2)
        begin
            return RUN_RISING;
        end
        else if (r <= 4)
        begin
            return RUN_SHUFFLED;
        end
        return RUN_NARROW;
    endfunction

    initial
    begin
        int phase_items;
        int len;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single element, both extremes
        run_vals = '{32'sh8000_0000};
        send_run();
        run_vals = '{32'sh7fff_ffff};
        send_run();
        // strictly rising through the extremes: split everywhere
        run_vals = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sh7fff_ffff};
        send_run();
        // falling: no split points
        run_vals = '{32'sd5, 32'sd3, 32'sd1};
        send_run();
        // equal values count as splits
        run_vals = '{32'sd7, 32'sd7, 32'sd7, 32'sd7};
        send_run();
        run_vals = '{32'sd3, 32'sd1, 32'sd2, 32'sd5, 32'sd4, 32'sd6};
        send_run();
        run_vals = '{32'sh7fff_ffff, 32'sh8000_0000};
        send_run();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // one run past capacity: the tail is dropped and flagged
            if (phase == 2)
            begin
                build_run(MAX_ITEMS + $urandom_range(1, 3), pick_kind());
                send_run();
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 10);
                build_run(len, pick_kind());
                send_run();
                phase_items += len;
            end
            // hold off input until every result of the phase is out
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (pending != 0)
            begin
                @(negedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
